// ===== rtl/imu_rlac_pkg.sv =====
// Shared types, register indexes, reset values and the saturation helper
// for the IMU rotation and lever-arm correction block. No dependencies.
package imu_rlac_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // Register indexes.
    localparam cfg_idx_t REG_ROT_ROW0    = 3'd0;
    localparam cfg_idx_t REG_ROT_ROW1    = 3'd1;
    localparam cfg_idx_t REG_ROT_ROW2    = 3'd2;
    localparam cfg_idx_t REG_MOUNT_OFFSET = 3'd3;

    // Reset values: identity matrix and zero translation.
    localparam cfg_data_t ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam cfg_data_t ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam cfg_data_t ROT_ROW2_RST = 48'h4000_0000_0000;
    localparam cfg_data_t OFFSET_RST   = 48'h0000_0000_0000;

    // Sample and coefficient types.
    typedef logic signed [31:0] q16_t;     // Q16.16 sample
    typedef logic signed [15:0] coef_t;    // Q2.14 coefficient
    typedef logic signed [16:0] lever_t;   // Q4.12 lever arm, one extra bit
    typedef logic signed [47:0] prod_t;    // coefficient times sample
    typedef logic signed [49:0] psum_t;    // sum of three products

    // Width of the operand taken by the saturation helper.
    localparam int SAT_W = 68;

    typedef logic signed [SAT_W-1:0] wide_t;

    // Clamp a wide signed value into the 32-bit two's complement range.
    function automatic q16_t sat32(input wide_t x);
        q16_t r;
        if (x > wide_t'(64'sh0000_0000_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < wide_t'(-64'sh0000_0000_8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/imu_rotate_lever_arm_correct.sv =====
// Top level of the IMU frame rotation with centripetal lever-arm correction.
// Depends on imu_rlac_pkg for types, register indexes and saturation.
//
// Usage: each input word carries one IMU sample, three angular rates and
// three accelerations in signed Q16.16, on a valid/ready channel (s_ ports).
// The block rotates both vectors by the configured 3x3 matrix (Q2.14), adds
// the centripetal term w(w.d) - d|w|^2 for lever arm d = -offset (Q4.12),
// and returns one result word (m_ ports) per input word, saturated to Q16.16.
//
// Each accepted word passes through every register stage before m_valid
// rises. Throughput is one word per cycle unless the receiver stalls: six
// register stages, each holding about one multiplier or one wide add with
// rounding and saturation, and every stage has its own valid bit. When the
// receiver stalls, the stalled words hold in place while empty stages behind
// them keep filling, so s_ready drops only once all six stages are occupied.
//
// Reset (aresetn low at a clock edge) empties the pipeline and loads the
// identity matrix and a zero offset. Configuration writes through cfg_wr_en,
// cfg_index and cfg_wdata take effect at once; they belong to idle periods.
module imu_rotate_lever_arm_correct (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  imu_rlac_pkg::cfg_idx_t     cfg_index,
    input  imu_rlac_pkg::cfg_data_t    cfg_wdata,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  imu_rlac_pkg::q16_t         s_rate_x,
    input  imu_rlac_pkg::q16_t         s_rate_y,
    input  imu_rlac_pkg::q16_t         s_rate_z,
    input  imu_rlac_pkg::q16_t         s_accel_x,
    input  imu_rlac_pkg::q16_t         s_accel_y,
    input  imu_rlac_pkg::q16_t         s_accel_z,

    output logic                       m_valid,
    input  logic                       m_ready,
    output imu_rlac_pkg::q16_t         m_rot_rate_x,
    output imu_rlac_pkg::q16_t         m_rot_rate_y,
    output imu_rlac_pkg::q16_t         m_rot_rate_z,
    output imu_rlac_pkg::q16_t         m_corr_accel_x,
    output imu_rlac_pkg::q16_t         m_corr_accel_y,
    output imu_rlac_pkg::q16_t         m_corr_accel_z
);
    import imu_rlac_pkg::*;

    localparam int NSTG = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cfg_data_t rot_row_reg [3];
    cfg_data_t offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_row_reg[0] <= ROT_ROW0_RST;
            rot_row_reg[1] <= ROT_ROW1_RST;
            rot_row_reg[2] <= ROT_ROW2_RST;
            offset_reg     <= OFFSET_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ROT_ROW0:     rot_row_reg[0] <= cfg_wdata;
                REG_ROT_ROW1:     rot_row_reg[1] <= cfg_wdata;
                REG_ROT_ROW2:     rot_row_reg[2] <= cfg_wdata;
                REG_MOUNT_OFFSET: offset_reg     <= cfg_wdata;
                default: begin
                    // Indexes past the register list are ignored.
                end
            endcase
        end
    end

    // Unpacked coefficients and lever arm. The lever arm is the negated
    // offset, one bit wider so that negating -8.0 gives +8.0.
    coef_t  coef [3][3];
    lever_t lever [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[i][j] = $signed(rot_row_reg[i][16*j +: 16]);
            end
            lever[i] = 17'sd0 - lever_t'($signed(offset_reg[16*i +: 16]));
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage may load when it is empty or when the
    // stage ahead of it is moving.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: matrix products for both vectors.
    // ------------------------------------------------------------------
    q16_t  rate_in [3];
    q16_t  accel_in [3];
    prod_t rprod_reg [3][3];
    prod_t aprod_reg [3][3];

    assign rate_in[0]  = s_rate_x;
    assign rate_in[1]  = s_rate_y;
    assign rate_in[2]  = s_rate_z;
    assign accel_in[0] = s_accel_x;
    assign accel_in[1] = s_accel_y;
    assign accel_in[2] = s_accel_z;

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    rprod_reg[i][j] <= coef[i][j] * rate_in[j];
                    aprod_reg[i][j] <= coef[i][j] * accel_in[j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row sums. The rate rows are rounded to Q16.16 and clamped.
    // ------------------------------------------------------------------
    logic signed [50:0] rsum [3];
    q16_t               w_next [3];
    psum_t              a_next [3];
    q16_t               w2_reg [3];
    psum_t              a2_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rsum[i] = 51'(rprod_reg[i][0]) + 51'(rprod_reg[i][1])
                    + 51'(rprod_reg[i][2]) + 51'sd8192;
            w_next[i] = sat32(SAT_W'(rsum[i] >>> 14));
            a_next[i] = psum_t'(aprod_reg[i][0]) + psum_t'(aprod_reg[i][1])
                      + psum_t'(aprod_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            w2_reg <= w_next;
            a2_reg <= a_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: w.d terms and squares of w.
    // ------------------------------------------------------------------
    logic signed [48:0] wdp_reg [3];
    logic signed [63:0] wsq_full [3];
    logic [62:0]        wwp_reg [3];
    q16_t               w3_reg [3];
    psum_t              a3_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wsq_full[i] = w2_reg[i] * w2_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                wdp_reg[i] <= w2_reg[i] * lever[i];
                // A square never exceeds 2^62, so 63 bits hold it unsigned.
                wwp_reg[i] <= wsq_full[i][62:0];
            end
            w3_reg <= w2_reg;
            a3_reg <= a2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: dot product w.d (Q16.16, clamped) and |w|^2 (clamped to the
    // positive Q16.16 maximum).
    // ------------------------------------------------------------------
    logic signed [50:0] wdsum;
    logic [63:0]        sqsum;
    logic [47:0]        sqsh;
    q16_t               wd_reg;
    logic [30:0]        wsq_reg;
    q16_t               w4_reg [3];
    psum_t              a4_reg [3];

    always_comb begin
        wdsum = 51'(wdp_reg[0]) + 51'(wdp_reg[1]) + 51'(wdp_reg[2]) + 51'sd2048;
        sqsum = 64'(wwp_reg[0]) + 64'(wwp_reg[1]) + 64'(wwp_reg[2]) + 64'd32768;
        sqsh  = sqsum[63:16];
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            wd_reg  <= sat32(SAT_W'(wdsum >>> 12));
            wsq_reg <= (sqsh > 48'h0000_7FFF_FFFF) ? 31'h7FFF_FFFF : sqsh[30:0];
            w4_reg  <= w3_reg;
            a4_reg  <= a3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: centripetal products w_i*wd and d_i*|w|^2.
    // ------------------------------------------------------------------
    logic signed [63:0] pw_reg [3];
    logic signed [48:0] qd_reg [3];
    q16_t               w5_reg [3];
    psum_t              a5_reg [3];
    logic signed [31:0] wsq_s;

    assign wsq_s = $signed({1'b0, wsq_reg});

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                pw_reg[i] <= w4_reg[i] * wd_reg;
                qd_reg[i] <= lever[i] * wsq_s;
            end
            w5_reg <= w4_reg;
            a5_reg <= a4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: combine in Q.32, round to Q16.16 and clamp. Output register.
    // ------------------------------------------------------------------
    logic signed [66:0] total [3];
    q16_t               rate_out_reg [3];
    q16_t               accel_out_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            total[i] = (67'(a5_reg[i]) <<< 2) + 67'(pw_reg[i])
                     - (67'(qd_reg[i]) <<< 4) + 67'sd32768;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            for (int i = 0; i < 3; i++) begin
                rate_out_reg[i]  <= w5_reg[i];
                accel_out_reg[i] <= sat32(SAT_W'(total[i] >>> 16));
            end
        end
    end

    assign m_rot_rate_x   = rate_out_reg[0];
    assign m_rot_rate_y   = rate_out_reg[1];
    assign m_rot_rate_z   = rate_out_reg[2];
    assign m_corr_accel_x = accel_out_reg[0];
    assign m_corr_accel_y = accel_out_reg[1];
    assign m_corr_accel_z = accel_out_reg[2];

`ifndef SYNTHESIS
    // An accepted word always occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> vld_reg[0])
        else $error("accepted word did not enter the first stage");

    // An empty first stage can always take a word.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[0] |-> s_ready)
        else $error("input stalled with an empty first stage");

    // With every stage full and the receiver stalled, nothing is accepted.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        ((&vld_reg) && !m_ready) |-> !s_ready)
        else $error("input accepted while the pipeline was full and stalled");
`endif

endmodule
